FILE: src/stable_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// stable priority queue assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SPQ_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stable_priority_queue: same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stable_priority_queue: next-cycle check failed");

`endif

FILE: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types, sizes and codes of the stable priority queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEPTH   = 8;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int TAG_W   = 64;
   localparam int LEVEL_W = 3;
   localparam int OCC_W   = 4;

   localparam logic [LEVEL_W-1:0] LEVEL_MIN = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd4;

   // occupancy as reported when every cell is held
   localparam logic [OCC_W-1:0] OCC_AT_FULL = OCC_W'(DEPTH);

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_POP    = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [LEVEL_W-1:0] level;
   } slot_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic               shift_ins;
      logic               shift_pop;
      logic [TAG_W-1:0]   new_tag;
      logic [LEVEL_W-1:0] new_level;
      logic [CNT_W-1:0]   count;
   } ctl_type;

   function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] raw);
      logic [LEVEL_W-1:0] v;
      v = raw;
      if (raw < LEVEL_MIN) begin
         v = LEVEL_MIN;
      end else if (raw > LEVEL_MAX) begin
         v = LEVEL_MAX;
      end
      return v;
   endfunction

endpackage

FILE: src/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if
// request channel: insert or pop beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spq_req_if;
   logic                               valid;
   logic                               ready;
   logic                               func;
   logic [spq_pkg::TAG_W-1:0]          entry_tag;
   logic [spq_pkg::LEVEL_W-1:0]        entry_level;

   modport source (output valid, output func, output entry_tag, output entry_level,
                   input ready);
   modport sink   (input valid, input func, input entry_tag, input entry_level,
                   output ready);
endinterface

FILE: src/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if
// response channel: one beat per request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic [spq_pkg::TAG_W-1:0]          served_tag;
   logic [spq_pkg::LEVEL_W-1:0]        served_level;
   logic [spq_pkg::OCC_W-1:0]          occupancy;

   modport source (output valid, output status, output served_tag,
                   output served_level, output occupancy, input ready);
   modport sink   (input valid, input status, input served_tag,
                   input served_level, input occupancy, output ready);
endinterface

FILE: src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds, takes the new entry, or shifts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
   input  logic                        clock,
   input  spq_pkg::ctl_type            ctl,
   input  logic [spq_pkg::CNT_W-1:0]   cell_index,
   input  spq_pkg::slot_type           prev_slot,
   input  logic                        prev_keep,
   input  spq_pkg::slot_type           next_slot,
   output spq_pkg::slot_type           slot,
   output logic                        keep
);

   spq_pkg::slot_type slot_ff;
   spq_pkg::slot_type slot_in;
   logic              occupied;

   assign occupied = cell_index < ctl.count;
   // an occupied entry of equal or higher level stays ahead of the new one
   assign keep     = occupied && (slot_ff.level >= ctl.new_level);
   assign slot     = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      if (ctl.shift_ins) begin
         if (keep) begin
            slot_in = slot_ff;
         end else if (prev_keep) begin
            slot_in.tag   = ctl.new_tag;
            slot_in.level = ctl.new_level;
         end else begin
            slot_in = prev_slot;
         end
      end else if (ctl.shift_pop) begin
         slot_in = next_slot;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

FILE: src/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded priority queue, levels 1 to 4, first in first out among equals
// ----------------------------------------------------------------------------
//  channel | dir | beat contents                                | handshake
//  req     | in  | func, entry_tag, entry_level                 | valid/ready
//  rsp     | out | status, served_tag, served_level, occupancy  | valid/ready
//
//  one request beat per clock cycle while rsp is not stalled; its response beat appears the next cycle
//  the rate is set by the cell chain, which sorts in a single shift step
//  a registered response stage lets a new request in while rsp is taken
//  synchronous reset empties the queue (entry count to zero), no clearing pass
//  a stalled rsp holds its beat and holds req off until it is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stable_priority_queue (
   input  logic         clock,
   input  logic         reset,
   spq_req_if.sink      req,
   spq_rsp_if.source    rsp
);

   localparam int DEPTH = spq_pkg::DEPTH;
   localparam int CNT_W = spq_pkg::CNT_W;

   // entry count, the only control state of the store
   logic [CNT_W-1:0]                 count_ff;
   logic [CNT_W-1:0]                 count_in;

   // response register
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [1:0]                       status_ff;
   logic [1:0]                       status_in;
   logic [spq_pkg::TAG_W-1:0]        served_tag_ff;
   logic [spq_pkg::TAG_W-1:0]        served_tag_in;
   logic [spq_pkg::LEVEL_W-1:0]      served_level_ff;
   logic [spq_pkg::LEVEL_W-1:0]      served_level_in;

   logic                             accept;
   logic                             is_insert;
   logic                             full;
   logic                             empty;
   spq_pkg::ctl_type                 ctl;

   spq_pkg::slot_type                slot_w [DEPTH];
   logic                             keep_w [DEPTH];

   // response stage frees up as its beat is taken
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign is_insert = req.func == spq_pkg::FUNC_INSERT;
   assign full      = count_ff == CNT_W'(DEPTH);
   assign empty     = count_ff == '0;

   // broadcast to the chain
   always_comb begin
      ctl.shift_ins = accept && is_insert && !full;
      ctl.shift_pop = accept && !is_insert && !empty;
      ctl.new_tag   = req.entry_tag;
      ctl.new_level = spq_pkg::clamp_level(req.entry_level);
      ctl.count     = count_ff;
   end

   // cell 0 is the front; each cell looks at its neighbours only
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::slot_type prev_slot;
      spq_pkg::slot_type next_slot;
      logic              prev_keep;

      if (i == 0) begin : g_front
         // nothing ahead: the front takes the new entry unless it keeps
         assign prev_slot = slot_w[i];
         assign prev_keep = 1'b1;
      end else begin : g_inner
         assign prev_slot = slot_w[i-1];
         assign prev_keep = keep_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_back
         // tail cell falls out of range after a pop, contents do not matter
         assign next_slot = slot_w[i];
      end else begin : g_mid
         assign next_slot = slot_w[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_index (CNT_W'(i)),
         .prev_slot  (prev_slot),
         .prev_keep  (prev_keep),
         .next_slot  (next_slot),
         .slot       (slot_w[i]),
         .keep       (keep_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.shift_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.shift_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // response built from the front cell before it shifts
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      status_in       = status_ff;
      served_tag_in   = served_tag_ff;
      served_level_in = served_level_ff;
      if (accept) begin
         rsp_valid_in    = 1'b1;
         status_in       = spq_pkg::STATUS_DONE;
         served_tag_in   = '0;
         served_level_in = '0;
         if (is_insert) begin
            if (full) begin
               status_in = spq_pkg::STATUS_FULL;
            end
         end else if (empty) begin
            status_in = spq_pkg::STATUS_EMPTY;
         end else begin
            served_tag_in   = slot_w[0].tag;
            served_level_in = slot_w[0].level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the response stage, loaded on accept only
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff       <= status_in;
         served_tag_ff   <= served_tag_in;
         served_level_ff <= served_level_in;
      end
   end

   // occupancy follows the count, masked to the field width
   logic [spq_pkg::OCC_W-1:0] occ_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         occ_ff <= spq_pkg::OCC_W'(count_in);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.served_tag   = served_tag_ff;
   assign rsp.served_level = served_level_ff;
   assign rsp.occupancy    = occ_ff;

endmodule

FILE: src/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks of the stable priority queue, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stable_priority_queue_assert.svh"

module spq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         rsp_status,
   input logic [spq_pkg::TAG_W-1:0]          rsp_served_tag,
   input logic [spq_pkg::LEVEL_W-1:0]        rsp_served_level,
   input logic [spq_pkg::OCC_W-1:0]          rsp_occupancy
);

   logic [1 + spq_pkg::TAG_W + spq_pkg::LEVEL_W + spq_pkg::OCC_W:0] rsp_beat;
   logic rsp_stall;
   logic full_beat;
   logic empty_beat;
   logic served_beat;
   logic occ_at_full;
   logic nothing_served;
   logic level_legal;

   assign rsp_beat       = {rsp_status, rsp_served_tag, rsp_served_level, rsp_occupancy};
   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign full_beat      = rsp_valid && rsp_status == spq_pkg::STATUS_FULL;
   assign empty_beat     = rsp_valid && rsp_status == spq_pkg::STATUS_EMPTY;
   assign served_beat    = rsp_valid && rsp_served_level != '0;
   assign occ_at_full    = rsp_occupancy == spq_pkg::OCC_AT_FULL;
   assign nothing_served = rsp_occupancy == '0 && rsp_served_tag == '0 &&
                           rsp_served_level == '0;
   assign level_legal    = rsp_served_level >= spq_pkg::LEVEL_MIN &&
                           rsp_served_level <= spq_pkg::LEVEL_MAX;

   // a stalled response beat keeps its contents
   `SPQ_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_beat))

   // a refused insert only happens with every cell held
   `SPQ_ASSERT_SAME(a_full_occ, full_beat, occ_at_full)

   // a refused pop reports an empty queue and no entry
   `SPQ_ASSERT_SAME(a_empty_rsp, empty_beat, nothing_served)

   // every accepted request gives a response beat in the next cycle
   `SPQ_ASSERT_NEXT(a_req_to_rsp, req_valid && req_ready, rsp_valid)

   // a served entry always carries a clamped level
   `SPQ_ASSERT_SAME(a_level_range, served_beat, level_legal)

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_status       (rsp.status),
   .rsp_served_tag   (rsp.served_tag),
   .rsp_served_level (rsp.served_level),
   .rsp_occupancy    (rsp.occupancy)
);
